// File: hdl/kmp_stream_matcher_macros.svh
// ----------------------------------------------------------------------------
// kmp_stream_matcher_macros
// Assertion macros shared by the matcher's checker.
// ----------------------------------------------------------------------------
`ifndef KMP_STREAM_MATCHER_MACROS_SVH
`define KMP_STREAM_MATCHER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define KMP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define KMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Payload types, codes and controller/datapath interface of the matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_END     = 2'd3
  } kmp_cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_EMPTY_TEXT = 3'd2,
    ST_EMPTY_PAT  = 3'd3,
    ST_TOO_LONG   = 3'd4
  } kmp_status_e;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } kmp_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] match_position;
    logic [31:0] match_count;
    logic [2:0]  status;
    logic        last;
  } kmp_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic drop;
    logic build_first;
    logic init_build;
    logic init_text;
    logic step;
    logic build_commit;
    logic text_commit;
    logic skip_text;
    logic tail_sel;
    logic emit_match;
    logic emit_sum;
  } kmp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kmp_cmd_e command;
    logic     full;
    logic     empty;
    logic     usable;
    logic     hit;
    logic     j_zero;
    logic     complete;
    logic     out_free;
  } kmp_stat_t;

endpackage

`default_nettype wire

// File: hdl/kmp_ram.sv
// ----------------------------------------------------------------------------
// kmp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/kmp_ctrl.sv
// ----------------------------------------------------------------------------
// kmp_ctrl
// Sequencer: decodes each request and walks the failure links.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_ctrl import kmp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire kmp_stat_t st,
  output kmp_ctrl_t      ctl
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_READ   = 7'b0000100,
    S_CMP    = 7'b0001000,
    S_TAIL   = 7'b0010000,
    S_MATCH  = 7'b0100000,
    S_SUM    = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (st.command)
          CMD_CLEAR: begin
            ctl.clear = 1'b1;
          end
          CMD_PATTERN: begin
            if (st.full) begin
              ctl.drop = 1'b1;
            end else if (st.empty) begin
              ctl.build_first = 1'b1;
            end else begin
              ctl.init_build = 1'b1;
              state_next     = S_READ;
            end
          end
          CMD_TEXT: begin
            if (st.usable) begin
              ctl.init_text = 1'b1;
              state_next    = S_READ;
            end else begin
              ctl.skip_text = 1'b1;
            end
          end
          CMD_END: begin
            state_next = S_SUM;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        // mismatch with a nonzero prefix: follow the failure link
        if (!st.hit && !st.j_zero) begin
          ctl.step   = 1'b1;
          state_next = S_READ;
        end else if (st.command == CMD_PATTERN) begin
          ctl.build_commit = 1'b1;
          state_next       = S_IDLE;
        end else if (st.complete) begin
          state_next = S_TAIL;
        end else begin
          ctl.text_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_TAIL: begin
        ctl.tail_sel = 1'b1;
        state_next   = S_MATCH;
      end
      S_MATCH: begin
        ctl.tail_sel = 1'b1;
        if (st.out_free) begin
          ctl.emit_match = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_SUM: begin
        if (st.out_free) begin
          ctl.emit_sum = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/kmp_dpath.sv
// ----------------------------------------------------------------------------
// kmp_dpath
// Pattern and prefix memories, scan counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_dpath import kmp_pkg::*; #(
  parameter int MAX_PATTERN = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire kmp_in_t   cmd_item,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data,
  input  wire kmp_ctrl_t ctl,
  output kmp_stat_t      st,
  output logic           res_valid,
  input  wire logic      res_ready,
  output kmp_out_t       res_item
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);

  kmp_in_t        cmd;
  logic [LW-1:0]  plen;
  logic [AW-1:0]  blen;
  logic [AW-1:0]  mlen;
  logic [AW-1:0]  j;
  logic [31:0]    pos;
  logic [31:0]    cnt;
  logic           stopped;
  logic           ovf;
  logic           stop_first;

  logic [7:0]     pat_rd;
  logic [AW-1:0]  pre_rd;
  logic [AW-1:0]  pre_raddr;
  logic [AW-1:0]  jn;
  logic [AW-1:0]  pre_wdata;
  logic           ram_we;
  logic           hit;
  logic           restart;
  logic [31:0]    pos_inc;
  logic [31:0]    cnt_inc;
  logic [31:0]    start;
  kmp_status_e    sum_status;

  assign hit       = (pat_rd == cmd.data_byte);
  assign jn        = hit ? j + AW'(1) : j;
  assign pre_raddr = ctl.tail_sel ? j : ((j == '0) ? '0 : j - AW'(1));
  assign ram_we    = ctl.build_commit | ctl.build_first;
  assign pre_wdata = ctl.build_first ? '0 : jn;
  assign pos_inc   = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
  assign cnt_inc   = (cnt == 32'hFFFF_FFFF) ? cnt : cnt + 32'd1;
  assign start     = pos - (32'(plen) - 32'd1);
  assign restart   = ctl.clear | ctl.drop | ctl.build_first | ctl.build_commit | ctl.emit_sum;

  kmp_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(plen)),
    .wdata (cmd.data_byte),
    .raddr (j),
    .rdata (pat_rd)
  );

  kmp_ram #(.WIDTH(AW), .DEPTH(MAX_PATTERN)) u_pre_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(plen)),
    .wdata (pre_wdata),
    .raddr (pre_raddr),
    .rdata (pre_rd)
  );

  always_comb begin
    if (pos == 32'd0) begin
      sum_status = ST_EMPTY_TEXT;
    end else if (plen == '0) begin
      sum_status = ST_EMPTY_PAT;
    end else if (ovf) begin
      sum_status = ST_TOO_LONG;
    end else if (cnt != 32'd0) begin
      sum_status = ST_OK;
    end else begin
      sum_status = ST_NOT_FOUND;
    end
  end

  always_comb begin
    st.command  = kmp_cmd_e'(cmd.command);
    st.full     = (plen == LW'(MAX_PATTERN));
    st.empty    = (plen == '0);
    st.usable   = (plen != '0) && !ovf && !stopped;
    st.hit      = hit;
    st.j_zero   = (j == '0);
    st.complete = hit && ((LW'(j) + LW'(1)) == plen);
    st.out_free = !res_valid || res_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      plen       <= '0;
      blen       <= '0;
      mlen       <= '0;
      pos        <= '0;
      cnt        <= '0;
      stopped    <= 1'b0;
      ovf        <= 1'b0;
      stop_first <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        stop_first <= cfg_data;
      end
      if (ctl.emit_match || ctl.emit_sum) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (ctl.clear) begin
        plen <= '0;
        blen <= '0;
        ovf  <= 1'b0;
      end
      if (ctl.drop) begin
        ovf <= 1'b1;
      end
      if (ctl.build_first) begin
        blen <= '0;
        plen <= plen + LW'(1);
      end
      if (ctl.build_commit) begin
        blen <= jn;
        plen <= plen + LW'(1);
      end
      if (ctl.text_commit) begin
        mlen <= jn;
        pos  <= pos_inc;
      end
      if (ctl.skip_text) begin
        pos <= pos_inc;
      end
      if (ctl.emit_match) begin
        // resume from the border of the whole pattern
        mlen      <= pre_rd;
        pos       <= pos_inc;
        cnt       <= cnt_inc;
        if (stop_first) begin
          stopped <= 1'b1;
        end
      end
      if (restart) begin
        pos     <= '0;
        cnt     <= '0;
        mlen    <= '0;
        stopped <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= cmd_item;
    end
    if (ctl.init_build) begin
      j <= blen;
    end
    if (ctl.init_text) begin
      j <= mlen;
    end
    if (ctl.step) begin
      j <= pre_rd;
    end
    if (ctl.emit_match) begin
      res_item.result_kind    <= KIND_MATCH;
      res_item.match_position <= start;
      res_item.match_count    <= cnt_inc;
      res_item.status         <= ST_OK;
      res_item.last           <= 1'b1;
    end
    if (ctl.emit_sum) begin
      res_item.result_kind    <= KIND_SUMMARY;
      res_item.match_position <= 32'd0;
      res_item.match_count    <= cnt;
      res_item.status         <= sum_status;
      res_item.last           <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kmp_stream_matcher.sv
// ----------------------------------------------------------------------------
// kmp_stream_matcher
// Streaming Knuth-Morris-Pratt byte matcher with online prefix table build.
//
//   channel  | role   | handshake            | payload
//   ---------+--------+----------------------+----------------
//   cmd      | input  | cmd_valid/cmd_ready  | cmd_item  (kmp_in_t)
//   res      | output | res_valid/res_ready  | res_item  (kmp_out_t)
//   cfg      | input  | cfg_we, no wait      | cfg_data  (stop_at_first)
//
// One request at a time: accept and decode end clear, dropped and first pattern
// bytes and unusable text bytes. Other pattern and text bytes add the read and
// compare states for the first comparison and for each failure link, at most
// pattern length links; a match adds S_TAIL and S_MATCH, end of text S_SUM.
// A full result register holds only the emitting state, and with it the input.
// Reset (rst, synchronous) empties the pattern and clears all scan counters.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_stream_matcher import kmp_pkg::*; #(
  parameter int MAX_PATTERN = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cmd_valid,
  output logic         cmd_ready,
  input  wire kmp_in_t cmd_item,
  output logic         res_valid,
  input  wire logic    res_ready,
  output kmp_out_t     res_item,
  input  wire logic    cfg_we,
  input  wire logic    cfg_data
);

  kmp_ctrl_t ctl;
  kmp_stat_t st;

  kmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .st        (st),
    .ctl       (ctl)
  );

  kmp_dpath #(.MAX_PATTERN(MAX_PATTERN)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd_item  (cmd_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .st        (st),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

`default_nettype wire

// File: hdl/kmp_checker.sv
// ----------------------------------------------------------------------------
// kmp_checker
// Port-level checks on the matcher's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kmp_stream_matcher_macros.svh"

module kmp_checker import kmp_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     res_valid,
  input wire logic     res_ready,
  input wire kmp_out_t res_item
);

  logic res_stall;
  logic is_match;
  logic is_sum;
  logic match_fields_ok;
  logic sum_fields_ok;

  assign res_stall       = res_valid && !res_ready;
  assign is_match        = res_valid && (res_item.result_kind == KIND_MATCH);
  assign is_sum          = res_valid && (res_item.result_kind == KIND_SUMMARY);
  assign match_fields_ok = (res_item.status == ST_OK) && (res_item.match_count != 32'd0);
  assign sum_fields_ok   = (res_item.match_position == 32'd0) &&
                           ((res_item.status == ST_OK) ||
                            (res_item.status == ST_NOT_FOUND) ||
                            (res_item.status == ST_EMPTY_TEXT) ||
                            (res_item.status == ST_EMPTY_PAT) ||
                            (res_item.status == ST_TOO_LONG));

  `KMP_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !res_valid, "result valid after reset")

  `KMP_ASSERT(a_res_hold, clk, rst, res_stall |=> res_valid && $stable(res_item), "result changed")

  `KMP_ASSERT(a_last_set, clk, rst, res_valid |-> res_item.last, "result without last")

  `KMP_ASSERT(a_match_ok, clk, rst, is_match |-> match_fields_ok, "bad match report")

  `KMP_ASSERT(a_sum_form, clk, rst, is_sum |-> sum_fields_ok, "bad summary")

endmodule

bind kmp_stream_matcher kmp_checker u_kmp_checker (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for kmp_stream_matcher. Commands go in over a
// valid/ready channel with random gaps. A scoreboard keeps its own copy of
// the pattern, the prefix table and the scan counters, predicts each match
// report and end-of-text summary, and compares every accepted result field by
// field. A directed opener is followed by random scans under both settings
// of stop_at_first, including a long receiver stall and a full drain.
// ----------------------------------------------------------------------------

module testbench;
  import kmp_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int PHASE_ITEMS   = 200;

  class match_scoreboard;
    localparam int PAT_DEPTH = 64;

    bit [7:0]    pat_bytes [PAT_DEPTH];
    bit [6:0]    border [PAT_DEPTH];
    int unsigned pat_len;
    int unsigned build_len;
    int unsigned match_len;
    bit [31:0]   text_pos;
    bit [31:0]   hits;
    bit          halted;
    bit          overflowed;
    bit          stop_first;
    kmp_out_t    expected_q [$];
    int          errors;
    int          match_total;
    int          summaries;
    bit [4:0]    status_seen;

    function new();
      pat_len = 0;
      build_len = 0;
      overflowed = 0;
      stop_first = 0;
      errors = 0;
      match_total = 0;
      summaries = 0;
      status_seen = '0;
      restart_scan();
    endfunction

    function void restart_scan();
      text_pos = '0;
      hits = '0;
      match_len = 0;
      halted = 0;
    endfunction

    function int unsigned link_of(int unsigned k);
      if (k - 1 >= PAT_DEPTH) return 0;
      return border[k - 1];
    endfunction

    function bit [7:0] byte_at(int unsigned k);
      if (k >= PAT_DEPTH) return 8'h00;
      return pat_bytes[k];
    endfunction

    function kmp_out_t make_result(logic kind, bit [31:0] pos, bit [31:0] cnt,
                                   kmp_status_e st);
      kmp_out_t r;
      r.result_kind = kind;
      r.match_position = pos;
      r.match_count = cnt;
      r.status = st;
      r.last = 1'b1;
      return r;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the predicted state by one accepted request.
    function void note_request(kmp_in_t req);
      int unsigned k;
      int unsigned j;
      bit [7:0]    b;
      kmp_status_e st;
      b = req.data_byte;
      case (kmp_cmd_e'(req.command))
        CMD_CLEAR: begin
          pat_len = 0;
          build_len = 0;
          overflowed = 0;
          restart_scan();
        end
        CMD_PATTERN: begin
          if (pat_len >= PAT_DEPTH) begin
            overflowed = 1;
          end else begin
            pat_bytes[pat_len] = b;
            k = 0;
            if (pat_len != 0) begin
              k = build_len;
              while (k > 0 && byte_at(k) != b) k = link_of(k);
              if (byte_at(k) == b) k++;
            end
            border[pat_len] = k[6:0];
            build_len = k;
            pat_len++;
          end
          restart_scan();
        end
        CMD_TEXT: begin
          if (pat_len > 0 && !overflowed && !halted) begin
            j = match_len;
            while (j > 0 && byte_at(j) != b) j = link_of(j);
            if (byte_at(j) == b) j++;
            if (j >= pat_len) begin
              if (hits != 32'hFFFF_FFFF) hits++;
              expected_q.push_back(make_result(KIND_MATCH,
                                               text_pos - (pat_len - 1), hits, ST_OK));
              match_total++;
              j = link_of(pat_len);
              if (stop_first) halted = 1;
            end
            match_len = j;
          end
          if (text_pos != 32'hFFFF_FFFF) text_pos++;
        end
        default: begin
          if (text_pos == 0) st = ST_EMPTY_TEXT;
          else if (pat_len == 0) st = ST_EMPTY_PAT;
          else if (overflowed) st = ST_TOO_LONG;
          else if (hits > 0) st = ST_OK;
          else st = ST_NOT_FOUND;
          expected_q.push_back(make_result(KIND_SUMMARY, '0, hits, st));
          summaries++;
          status_seen[st] = 1'b1;
          restart_scan();
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(kmp_out_t got);
      kmp_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind=%0d pos=%0d count=%0d status=%0d",
                         got.result_kind, got.match_position, got.match_count,
                         got.status));
      end else begin
        want = expected_q.pop_front();
        if (got.result_kind !== want.result_kind)
          report($sformatf("result_kind %0d, want %0d", got.result_kind,
                           want.result_kind));
        if (got.match_position !== want.match_position)
          report($sformatf("match_position %0d, want %0d", got.match_position,
                           want.match_position));
        if (got.match_count !== want.match_count)
          report($sformatf("match_count %0d, want %0d", got.match_count,
                           want.match_count));
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.last !== want.last)
          report($sformatf("last %0d, want %0d", got.last, want.last));
      end
    endtask
  endclass

  logic     clk;
  logic     rst;
  logic     cmd_valid;
  logic     cmd_ready;
  kmp_in_t  cmd_item;
  logic     res_valid;
  logic     res_ready;
  kmp_out_t res_item;
  logic     cfg_we;
  logic     cfg_data;

  match_scoreboard sb;
  bit calm;
  bit hold_pending;
  int items_sent;
  int idle_cycles;

  kmp_stream_matcher uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(res_item);
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: random ready runs, a long hold when asked, steady ready when calm.
  initial begin : receiver
    int  run_left;
    bit  level;
    run_left = 0;
    level = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 0;
      end else if (calm) begin
        res_ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          level = ($urandom_range(0, 99) < 70);
          if (level) run_left = $urandom_range(1, 20);
          else if ($urandom_range(0, 99) < 85) run_left = $urandom_range(1, 3);
          else run_left = $urandom_range(10, 50);
        end
        run_left--;
        res_ready <= level;
      end
    end
  end

  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send_cmd(kmp_cmd_e c, logic [7:0] b);
    kmp_in_t req;
    int      gap;
    req.command = c;
    req.data_byte = b;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_item <= req;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sb.note_request(req);
    items_sent++;
  endtask

  // Hold off requests until every predicted result has been taken.
  task drain();
    cmd_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task set_stop_first(bit value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.stop_first = value;
  endtask

  // Short pattern repeated in the text while the receiver stalls: fill the
  // result path and back up the request channel.
  task squeeze();
    bit saved;
    int i;
    saved = calm;
    calm = 1;
    hold_pending = 1;
    send_cmd(CMD_CLEAR, 8'h00);
    send_cmd(CMD_PATTERN, 8'h3C);
    send_cmd(CMD_PATTERN, 8'h3C);
    for (i = 0; i < 40; i++) send_cmd(CMD_TEXT, 8'h3C);
    send_cmd(CMD_END, 8'h00);
    calm = saved;
  endtask

  task random_scan(bit force_long);
    bit [7:0] alpha [3];
    bit [7:0] pq [$];
    int       plen;
    int       tlen;
    int       nsym;
    int       r;
    int       i;
    int       k;
    if (!force_long && $urandom_range(0, 99) < 10) begin
      send_cmd(kmp_cmd_e'(2'($urandom_range(0, 3))), 8'($urandom));
      return;
    end
    for (i = 0; i < 3; i++) alpha[i] = 8'($urandom);
    nsym = $urandom_range(1, 3);
    if (force_long || $urandom_range(0, 4) != 0) send_cmd(CMD_CLEAR, 8'($urandom));
    r = $urandom_range(0, 99);
    if (force_long) plen = 66;
    else if (r < 85) plen = $urandom_range(1, 5);
    else if (r < 95) plen = $urandom_range(6, 20);
    else plen = $urandom_range(60, 70);
    for (i = 0; i < plen; i++) begin
      pq.push_back(alpha[$urandom_range(0, nsym - 1)]);
      send_cmd(CMD_PATTERN, pq[i]);
    end
    tlen = $urandom_range(0, 25) + ((plen > 20) ? plen : 0);
    i = 0;
    while (i < tlen) begin
      if ($urandom_range(0, 3) == 0 && pq.size() <= tlen - i) begin
        for (k = 0; k < pq.size(); k++) send_cmd(CMD_TEXT, pq[k]);
        i += pq.size();
      end else begin
        send_cmd(CMD_TEXT, alpha[$urandom_range(0, nsym - 1)]);
        i++;
      end
      // Break the scan now and then with a stray pattern byte.
      if ($urandom_range(0, 99) < 2) send_cmd(CMD_PATTERN, alpha[0]);
    end
    if ($urandom_range(0, 9) != 0) send_cmd(CMD_END, 8'($urandom));
  endtask

  initial begin : stimulus
    int  ph;
    int  start_count;
    bit  drained;
    bit  first;
    clk = 1'b0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_item = '0;
    res_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    calm = 0;
    hold_pending = 0;
    items_sent = 0;
    idle_cycles = 0;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_stop_first(1'b0);
    // Summary with no text, then with text but no pattern.
    send_cmd(CMD_END, 8'hFF);
    send_cmd(CMD_TEXT, 8'h00);
    send_cmd(CMD_END, 8'h00);
    // Overlapping matches on an all-ones pattern.
    send_cmd(CMD_PATTERN, 8'hFF);
    send_cmd(CMD_PATTERN, 8'hFF);
    repeat (3) send_cmd(CMD_TEXT, 8'hFF);
    send_cmd(CMD_END, 8'h00);
    // Pattern longer than the text.
    send_cmd(CMD_CLEAR, 8'h00);
    send_cmd(CMD_PATTERN, 8'h00);
    send_cmd(CMD_PATTERN, 8'h01);
    send_cmd(CMD_PATTERN, 8'h00);
    send_cmd(CMD_TEXT, 8'h01);
    send_cmd(CMD_END, 8'h00);
    // First match only, later text ignored.
    set_stop_first(1'b1);
    send_cmd(CMD_CLEAR, 8'hFF);
    send_cmd(CMD_PATTERN, 8'hAA);
    send_cmd(CMD_TEXT, 8'hAA);
    send_cmd(CMD_TEXT, 8'hAA);
    send_cmd(CMD_TEXT, 8'h55);
    send_cmd(CMD_END, 8'h00);

    first = 1;
    for (ph = 0; ph < 4; ph++) begin
      set_stop_first(ph[0]);
      calm = (ph == 2);
      if (ph == 0) squeeze();
      start_count = items_sent;
      drained = 0;
      while (items_sent - start_count < PHASE_ITEMS) begin
        random_scan(first);
        first = 0;
        if (ph[0] && !drained && items_sent - start_count > PHASE_ITEMS / 2) begin
          drain();
          drained = 1;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests: %0d match reports, %0d summaries, stop_at_first 0 and 1.",
             items_sent, sb.match_total, sb.summaries);
    $display("Summary status codes seen (one bit per code, code 0 rightmost): %b",
             sb.status_seen);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
